/* rtl/ibhq_pkg.sv */
// ----------------------------------------------------------------------------
// ibhq_pkg
// Shared types and codes for the indexed binary-heap queue unit.
// ----------------------------------------------------------------------------
package ibhq_pkg;

    // item operation codes
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_PEEK   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_JOB    = 2'd3;

    // register index
    localparam logic [0:0] REG_ORDER_MODE = 1'd0;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_POS,
        S_RD_ROOT,
        S_RD_TARGET,
        S_RD_LAST,
        S_MOVE_LAST,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

endpackage

/* rtl/ibhq_heap_mem.sv */
// ----------------------------------------------------------------------------
// ibhq_heap_mem
// Slot memory holding key and job per heap slot; one write and two reads,
// read data registered.
// ----------------------------------------------------------------------------
module ibhq_heap_mem
    import ibhq_pkg::*;
#(
    parameter int AW = 8,
    parameter int KW = 32,
    parameter int JW = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [KW-1:0] wkey,
    input  logic [JW-1:0] wjob,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [KW-1:0] rkey_a,
    output logic [JW-1:0] rjob_a,
    output logic [KW-1:0] rkey_b,
    output logic [JW-1:0] rjob_b
);

    logic [KW+JW-1:0] mem [2**AW];

    // write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wkey, wjob};
        end
        {rkey_a, rjob_a} <= mem[raddr_a];
        {rkey_b, rjob_b} <= mem[raddr_b];
    end

endmodule

/* rtl/ibhq_pos_mem.sv */
// ----------------------------------------------------------------------------
// ibhq_pos_mem
// Position map: slot of each job, with a present bit per job in flops.
// ----------------------------------------------------------------------------
module ibhq_pos_mem
    import ibhq_pkg::*;
#(
    parameter int JS = 256,
    parameter int JA = 8,
    parameter int PW = 9
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [JA-1:0] waddr,
    input  logic [PW-1:0] wpos,
    input  logic          set_present,
    input  logic          clr_present,
    input  logic [JA-1:0] pres_addr,
    input  logic [JA-1:0] raddr,
    output logic [PW-1:0] rpos,
    output logic          present
);

    logic [PW-1:0] mem [JS];
    logic [JS-1:0] present_reg;

    // slot storage
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wpos;
        end
        rpos <= mem[raddr];
    end

    // present flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
        end
        else
        begin
            if (set_present)
            begin
                present_reg[pres_addr] <= 1'b1;
            end
            if (clr_present)
            begin
                present_reg[pres_addr] <= 1'b0;
            end
        end
    end

    assign present = present_reg[raddr];

endmodule

/* rtl/indexed_binary_heap_queue_unit.sv */
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue_unit
// Binary-heap priority queue of job handles with a position map for removal
// by handle; max-heap on key or min-heap on key by a register bit.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  in      | in_valid in_ready mode job_id key     | into block
//  out     | out_valid out_ready status out_job_id | out of block
//          | out_key entry_count                   |
//  cfg     | psel penable pwrite paddr pwdata      | APB register port
//
//  One item at a time. After acceptance the item reads the position map,
//  then the root or target slot and the last entry as its operation needs;
//  failed items finish without touching the heap. Push climbs, pop sifts
//  down and remove climbs or sifts down; each level is a read of the slot
//  memory and then a compare/write-back step. The unit idles between items.
//  Reset clears count, order bit and present flags at once; no clearing pass.
//  A held result does not block the next item from being accepted; that item
//  waits in its final state until the result register is free.
// ----------------------------------------------------------------------------
module indexed_binary_heap_queue_unit
    import ibhq_pkg::*;
#(
    parameter int HEAP_DEPTH = 256,
    parameter int KEY_BITS   = 32,
    parameter int JOB_SLOTS  = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  job_id,
    input  logic [31:0] key,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  out_job_id,
    output logic [31:0] out_key,
    output logic [8:0]  entry_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int JA = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
    localparam int JW = 8;
    localparam int KW = KEY_BITS;
    localparam int EW = (JA > JW) ? JA : JW;

    // configuration
    logic order_reg;
    wire  cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 1'b0;
        end
        else if (cfg_wr && paddr[1:1] == REG_ORDER_MODE)
        begin
            order_reg <= pwdata[0];
        end
    end
    assign prdata = (paddr[1:1] == REG_ORDER_MODE) ? {31'd0, order_reg} : 32'd0;

    function automatic logic better(input logic om, input logic [KW-1:0] a,
                                    input logic [KW-1:0] b);
        return om ? (a < b) : (a > b);
    endfunction

    // control and working registers
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    op_reg, op_next;
    logic [EW-1:0] ijob_reg, ijob_next;
    logic [KW-1:0] ikey_reg, ikey_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [KW-1:0] ckey_reg, ckey_next;
    logic [JW-1:0] cjob_reg, cjob_next;
    logic          ovalid_reg, ovalid_next;
    logic [1:0]    ost_reg, ost_next;
    logic [JW-1:0] ojob_reg, ojob_next;
    logic [KW-1:0] okey_reg, okey_next;

    // result register
    logic [1:0]    res_st_reg;
    logic [JW-1:0] res_job_reg;
    logic [KW-1:0] res_key_reg;
    logic [CW-1:0] res_cnt_reg;

    // memory ports
    logic          hwe;
    logic [AW-1:0] hwa, hra, hrb;
    logic [KW-1:0] hwk, rka, rkb;
    logic [JW-1:0] hwj, rja, rjb;
    logic          pwe, pset, pclr;
    logic [JA-1:0] pwa, ppa, pra;
    logic [AW-1:0] pwp;
    logic [AW:0]   rpos_w;
    logic          present;

    ibhq_heap_mem #(.AW(AW), .KW(KW), .JW(JW)) u_heap (
        .clk(clk), .we(hwe), .waddr(hwa), .wkey(hwk), .wjob(hwj),
        .raddr_a(hra), .raddr_b(hrb), .rkey_a(rka), .rjob_a(rja),
        .rkey_b(rkb), .rjob_b(rjb));

    ibhq_pos_mem #(.JS(JOB_SLOTS), .JA(JA), .PW(AW+1)) u_pos (
        .clk(clk), .rst_n(rst_n), .we(pwe), .waddr(pwa),
        .wpos({1'b0, pwp}), .set_present(pset), .clr_present(pclr),
        .pres_addr(ppa), .raddr(pra), .rpos(rpos_w), .present(present));

    wire [EW-1:0] in_job_ext = EW'(job_id);
    wire          job_ok     = ({1'b0, ijob_reg} < (EW+1)'(JOB_SLOTS));
    wire [AW-1:0] parent_idx = AW'((idx_reg - AW'(1)) >> 1);
    wire [CW:0]   lchild     = (CW+1)'({idx_reg, 1'b1});
    wire [CW:0]   rchild     = lchild + (CW+1)'(1);
    wire          out_free   = !ovalid_reg || out_ready;

    assign in_ready = (state_reg == S_IDLE);
    wire   in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        ijob_reg <= ijob_next;
        ikey_reg <= ikey_next;
        idx_reg  <= idx_next;
        ckey_reg <= ckey_next;
        cjob_reg <= cjob_next;
        ost_reg  <= ost_next;
        ojob_reg <= ojob_next;
        okey_reg <= okey_next;
    end

    // result register, loaded as the finished item leaves
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            res_st_reg  <= ost_reg;
            res_job_reg <= ojob_reg;
            res_key_reg <= okey_reg;
            res_cnt_reg <= count_reg;
        end
    end

    // sequencer
    always_comb
    begin
        logic [CW-1:0] last;
        logic          pick_r;
        logic [AW-1:0] cidx;
        state_next  = state_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        ijob_next   = ijob_reg;
        ikey_next   = ikey_reg;
        idx_next    = idx_reg;
        ckey_next   = ckey_reg;
        cjob_next   = cjob_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ost_next    = ost_reg;
        ojob_next   = ojob_reg;
        okey_next   = okey_reg;
        hwe = 1'b0; hwa = idx_reg; hwk = ckey_reg; hwj = cjob_reg;
        hra = idx_reg; hrb = idx_reg;
        pwe = 1'b0; pwa = JA'(cjob_reg); pwp = idx_reg;
        pset = 1'b0; pclr = 1'b0; ppa = JA'(ijob_reg);
        pra = JA'(job_id);
        last   = count_reg - CW'(1);
        pick_r = 1'b0;
        cidx   = AW'(lchild);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next   = mode;
                    ijob_next = in_job_ext;
                    ikey_next = KW'(key);
                    ost_next  = ST_OK;
                    ojob_next = '0;
                    okey_next = '0;
                    state_next = S_RD_POS;
                    hra = '0;
                end
            end
            S_RD_POS:
            begin
                // present flag and slot of the named job are in flops/regs now
                pra = JA'(ijob_reg);
                hra = '0;
                unique case (op_reg) inside
                    OP_PUSH:
                    begin
                        if (count_reg >= CW'(HEAP_DEPTH))
                        begin
                            ost_next = ST_FULL;
                            state_next = S_DONE;
                        end
                        else if (!job_ok || present)
                        begin
                            ost_next = ST_JOB;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next  = AW'(count_reg);
                            ckey_next = ikey_reg;
                            cjob_next = JW'(ijob_reg);
                            count_next = count_reg + CW'(1);
                            pset = 1'b1;
                            state_next = S_UP_RD;
                        end
                    end
                    OP_POP, OP_PEEK:
                    begin
                        if (count_reg == '0)
                        begin
                            ost_next = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RD_ROOT;
                        end
                    end
                    default:
                    begin
                        if (count_reg == '0)
                        begin
                            ost_next = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else if (!job_ok || !present)
                        begin
                            ost_next = ST_JOB;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RD_TARGET;
                        end
                    end
                endcase
            end
            S_RD_ROOT:
            begin
                // root data on port a
                ojob_next = rja;
                okey_next = rka;
                idx_next  = '0;
                if (op_reg == OP_PEEK)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ppa  = JA'(rja);
                    pclr = 1'b1;
                    count_next = last;
                    hrb = AW'(last);
                    state_next = (last == '0) ? S_DONE : S_RD_LAST;
                end
            end
            S_RD_TARGET:
            begin
                // slot of the named job is on the position read port
                pra = JA'(ijob_reg);
                if ({1'b0, rpos_w} >= (AW+2)'(count_reg))
                begin
                    ost_next = ST_JOB;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = AW'(rpos_w);
                    hra = AW'(rpos_w);
                    state_next = S_MOVE_LAST;
                    op_next = OP_REMOVE;
                end
            end
            S_MOVE_LAST:
            begin
                // target read on a; now fetch last
                ojob_next = rja;
                okey_next = rka;
                ppa  = JA'(rja);
                pclr = 1'b1;
                count_next = last;
                hrb = AW'(last);
                state_next = ((AW+1)'(idx_reg) == (AW+1)'(last)) ? S_DONE
                                                                 : S_RD_LAST;
            end
            S_RD_LAST:
            begin
                // last entry on port b; place it at idx
                ckey_next = rkb;
                cjob_next = rjb;
                hwe = 1'b1; hwk = rkb; hwj = rjb;
                pwe = 1'b1; pwa = JA'(rjb);
                hra = parent_idx;
                state_next = S_UP_CMP;
                op_next = OP_PEEK;
            end
            S_UP_RD:
            begin
                // place the moving entry and read its parent
                hwe = 1'b1;
                pwe = 1'b1;
                hra = parent_idx;
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                // parent on port a
                if (idx_reg != '0 && better(order_reg, ckey_reg, rka))
                begin
                    hwe = 1'b1; hwk = rka; hwj = rja;
                    pwe = 1'b1; pwa = JA'(rja);
                    idx_next = parent_idx;
                    op_next  = OP_POP;
                    state_next = S_UP_RD;
                end
                else if (op_reg == OP_PEEK)
                begin
                    // pop or removal refill that did not climb: sift down instead
                    hra = AW'(lchild);
                    hrb = AW'(rchild);
                    state_next = S_DN_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DN_RD:
            begin
                hwe = 1'b1;
                pwe = 1'b1;
                hra = AW'(lchild);
                hrb = AW'(rchild);
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (lchild >= (CW+1)'(count_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pick_r = (rchild < (CW+1)'(count_reg)) &&
                             !better(order_reg, rka, rkb);
                    cidx = pick_r ? AW'(rchild) : AW'(lchild);
                    if (better(order_reg, pick_r ? rkb : rka, ckey_reg))
                    begin
                        hwe = 1'b1;
                        hwk = pick_r ? rkb : rka;
                        hwj = pick_r ? rjb : rja;
                        pwe = 1'b1; pwa = JA'(hwj);
                        idx_next = cidx;
                        state_next = S_DN_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid   = ovalid_reg;
    assign status      = res_st_reg;
    assign out_job_id  = res_job_reg;
    assign out_key     = 32'(res_key_reg);
    assign entry_count = 9'(res_cnt_reg);

endmodule

/* rtl/ibhq_checker.sv */
// ----------------------------------------------------------------------------
// ibhq_checker
// Port-level checks of the heap queue unit, bound to the top level.
// ----------------------------------------------------------------------------
module ibhq_checker
    import ibhq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [8:0] entry_count,
    input logic [7:0] out_job_id
);

    // result held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
        && $stable(entry_count) && $stable(out_job_id))
        else $error("result dropped under stall");

    // one item in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // an empty status reports zero jobs
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> entry_count == 9'd0)
        else $error("empty status with jobs held");

    // failed items return no job
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> out_job_id == 8'd0)
        else $error("job returned on failure");

endmodule

bind indexed_binary_heap_queue_unit ibhq_checker u_ibhq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .entry_count(entry_count), .out_job_id(out_job_id));

/* tb/indexed_binary_heap_queue_unit_tb.sv */
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue_unit_tb
// Drives push, pop, remove and peek items through the heap queue under both
// orders, predicts each result with a behavioral heap, and compares fields.
// ----------------------------------------------------------------------------
module indexed_binary_heap_queue_unit_tb
    import ibhq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  job;
        logic [31:0] k;
    } heap_item_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [7:0]  job;
        logic [31:0] k;
        logic [8:0]  cnt;
    } heap_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = '0;
    logic [7:0]  job_id = '0;
    logic [31:0] key = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [7:0]  out_job_id;
    logic [31:0] out_key;
    logic [8:0]  entry_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    indexed_binary_heap_queue_unit dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow heap
    logic [31:0] sh_keys [DEPTH];
    logic [7:0]  sh_jobs [DEPTH];
    int          sh_pos [256];
    bit          sh_present [256];
    int          sh_count;
    bit          sh_min;

    heap_item_t   pending_items [$];
    heap_result_t expected_results [$];
    int  mismatches = 0;
    bit  sender_pause = 0;
    bit  long_stall = 0;

    function automatic void enqueue_item(heap_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void enqueue_result(heap_result_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic bit outranks(logic [31:0] a, logic [31:0] b);
        return sh_min ? (a < b) : (a > b);
    endfunction

    function automatic void put_slot(int i, logic [31:0] k, logic [7:0] j);
        sh_keys[i] = k;
        sh_jobs[i] = j;
        sh_pos[j] = i;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [31:0] ka;
        logic [7:0]  ja;
        ka = sh_keys[a];
        ja = sh_jobs[a];
        put_slot(a, sh_keys[b], sh_jobs[b]);
        put_slot(b, ka, ja);
    endfunction

    function automatic void climb(int i);
        int p;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!outranks(sh_keys[i], sh_keys[p])) break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void sink(int i);
        int l;
        int c;
        forever
        begin
            l = 2 * i + 1;
            if (l >= sh_count) break;
            c = l;
            if (l + 1 < sh_count && !outranks(sh_keys[l], sh_keys[l + 1])) c = l + 1;
            if (!outranks(sh_keys[c], sh_keys[i])) break;
            swap_slots(i, c);
            i = c;
        end
    endfunction

    function automatic void take_slot(int p);
        sh_present[sh_jobs[p]] = 0;
        sh_count--;
        if (p != sh_count)
        begin
            put_slot(p, sh_keys[sh_count], sh_jobs[sh_count]);
            if (p > 0 && outranks(sh_keys[p], sh_keys[(p - 1) / 2])) climb(p);
            else sink(p);
        end
    endfunction

    function automatic heap_result_t predict_heap_op(heap_item_t it);
        heap_result_t r;
        r = '0;
        r.st = ST_OK;
        case (it.op) inside
            OP_PUSH:
            begin
                if (sh_count >= DEPTH) r.st = ST_FULL;
                else if (sh_present[it.job]) r.st = ST_JOB;
                else
                begin
                    put_slot(sh_count, it.k, it.job);
                    sh_present[it.job] = 1;
                    sh_count++;
                    climb(sh_count - 1);
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (sh_count == 0) r.st = ST_EMPTY;
                else
                begin
                    r.job = sh_jobs[0];
                    r.k = sh_keys[0];
                    if (it.op == OP_POP) take_slot(0);
                end
            end
            default:
            begin
                if (sh_count == 0) r.st = ST_EMPTY;
                else if (!sh_present[it.job] || sh_pos[it.job] >= sh_count) r.st = ST_JOB;
                else
                begin
                    r.job = sh_jobs[sh_pos[it.job]];
                    r.k = sh_keys[sh_pos[it.job]];
                    take_slot(sh_pos[it.job]);
                end
            end
        endcase
        r.cnt = sh_count[8:0];
        return r;
    endfunction

    // driver: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                void'(pending_items.pop_front());
            end
            if (in_valid && !in_ready)
            begin
                // hold the item
            end
            else if (gap_left > 0 || sender_pause || pending_items.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
            else
            begin
                in_valid <= 1'b1;
                mode <= pending_items[0].op;
                job_id <= pending_items[0].job;
                key <= pending_items[0].k;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 30);
                    if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // prediction at acceptance
    always @(posedge clk)
    begin
        heap_item_t seen;
        seen.op = mode;
        seen.job = job_id;
        seen.k = key;
        if (rst_n && in_valid && in_ready)
            enqueue_result(predict_heap_op(seen));
    end

    // receiver: stall pattern plus one long hold-off
    int stall_phase = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            stall_phase <= (stall_phase + 1) % 23;
            if (long_stall) out_ready <= 1'b0;
            else if (stall_phase < 8) out_ready <= 1'b1;
            else out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result check
    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: status %0d job %0d key %h count %0d",
                             status, out_job_id, out_key, entry_count);
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.st !== status || want.job !== out_job_id
                    || want.k !== out_key || want.cnt !== entry_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st %0d job %0d key %h cnt %0d,",
                                  " got st %0d job %0d key %h cnt %0d"},
                                 want.st, want.job, want.k, want.cnt,
                                 status, out_job_id, out_key, entry_count);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || long_stall)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("indexed_binary_heap_queue_unit test failed");
            $finish;
        end
    end

    task automatic write_order(bit v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_ORDER_MODE, 1'b0};
        pwdata <= {31'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sh_min = v;
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    function automatic void add_item(logic [1:0] op, logic [7:0] j, logic [31:0] k);
        heap_item_t it;
        it.op = op;
        it.job = j;
        it.k = k;
        enqueue_item(it);
    endfunction

    // random phase, mostly pushes and pops, pushes mostly with narrow keys
    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                add_item(OP_PUSH, 8'($urandom_range(0, 255)),
                         ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20));
            else if (r < 70) add_item(OP_POP, 8'($urandom), $urandom);
            else if (r < 88) add_item(OP_REMOVE, 8'($urandom_range(0, 255)), $urandom);
            else add_item(OP_PEEK, 8'($urandom), $urandom);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            sh_present[i] = 0;
            sh_pos[i] = 0;
        end
        sh_count = 0;
        sh_min = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // directed: empty cases, extremes, duplicates, ties
        add_item(OP_POP, 8'd0, 32'd0);
        add_item(OP_PEEK, 8'd0, 32'd0);
        add_item(OP_REMOVE, 8'd5, 32'd0);
        add_item(OP_PUSH, 8'd0, 32'd0);
        add_item(OP_PUSH, 8'd255, 32'hFFFF_FFFF);
        add_item(OP_PUSH, 8'd255, 32'd7);
        add_item(OP_PUSH, 8'd10, 32'd7);
        add_item(OP_PUSH, 8'd11, 32'd7);
        add_item(OP_PUSH, 8'd12, 32'd7);
        add_item(OP_PEEK, 8'd0, 32'd0);
        add_item(OP_REMOVE, 8'd99, 32'd0);
        add_item(OP_REMOVE, 8'd11, 32'd0);
        add_item(OP_POP, 8'd0, 32'd0);
        add_item(OP_POP, 8'd0, 32'd0);
        add_item(OP_POP, 8'd0, 32'd0);
        add_item(OP_POP, 8'd0, 32'd0);
        add_item(OP_POP, 8'd0, 32'd0);
        add_item(OP_POP, 8'd0, 32'd0);
        drain();
        // fill to full under min order, then overflow
        write_order(1'b1);
        for (int i = 0; i < 256; i++)
            add_item(OP_PUSH, i[7:0], $urandom_range(0, 40));
        add_item(OP_PUSH, 8'd3, 32'd1);
        // long receiver hold-off while the sender keeps offering
        fork
        begin
            long_stall = 1;
            repeat (400) @(posedge clk);
            long_stall = 0;
        end
        join_none
        random_phase(300);
        drain();
        // order flip with jobs held
        write_order(1'b0);
        random_phase(500);
        // sender pause mid-stream until everything has come back
        wait (pending_items.size() < 250);
        sender_pause = 1;
        wait (!in_valid && expected_results.size() == 0);
        sender_pause = 0;
        drain();
        write_order(1'b1);
        random_phase(450);
        drain();
        write_order(1'b0);
        random_phase(450);
        drain();
        if (mismatches == 0)
            $display("indexed_binary_heap_queue_unit test passed");
        else
            $display("indexed_binary_heap_queue_unit test failed");
        $finish;
    end
endmodule
